// ===== hdl/rmsenv_pkg.sv =====
// Shared types, widths, register indexes and reset values for the RMS envelope follower.
// No dependencies; every other file in hdl/ imports this package.
package rmsenv_pkg;

   localparam int unsigned MAX_WINDOW   = 1024;
   localparam int unsigned MAX_CHANNELS = 2;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned SUM_W      = 41;
   localparam int unsigned CNT_W      = 11;
   localparam int unsigned FOS_W      = 20;
   localparam int unsigned GAIN_W     = 17;
   localparam int unsigned LVL_W      = 8;
   localparam int unsigned CH_W       = 2;
   localparam int unsigned MUL_W      = 17;
   localparam int unsigned PROD_W     = 2 * MUL_W;
   localparam int unsigned ROOT_W     = 16;
   localparam int unsigned RAD_W      = 31;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_CHANNEL_COUNT = 3'd0;
   localparam csr_index_type CSR_WINDOW_LEN    = 3'd1;
   localparam csr_index_type CSR_FRAME_CAP     = 3'd2;
   localparam csr_index_type CSR_GAIN_Q16      = 3'd3;
   localparam csr_index_type CSR_CEILING       = 3'd4;

   localparam logic [CH_W-1:0]   RST_CHANNEL_COUNT = 2'd1;
   localparam logic [CNT_W-1:0]  RST_WINDOW_LEN    = 11'd240;
   localparam logic [FOS_W-1:0]  RST_FRAME_CAP     = 20'd1920;
   localparam logic [GAIN_W-1:0] RST_GAIN_Q16      = 17'd26214;
   localparam logic [LVL_W-1:0]  RST_CEILING       = 8'd90;

endpackage

// ===== hdl/rmsenv_serial_mul.sv =====
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Depends on rmsenv_pkg for operand and product widths.
module rmsenv_serial_mul import rmsenv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MUL_W-1:0]  a,
   input  logic [MUL_W-1:0]  b,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   localparam int unsigned STEP_W = $clog2(MUL_W + 1);

   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [MUL_W-1:0]  mplier_ff, mplier_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = {{(PROD_W-MUL_W){1'b0}}, a};
         mplier_in = b;
         count_in  = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MUL_W-1:1]};
         count_in  = count_ff + 1'b1;
         if (count_ff == STEP_W'(MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== hdl/rmsenv_divider.sv =====
// Restoring divider: window sum over frame count, one quotient bit per cycle.
// Depends on rmsenv_pkg for the sum and count widths.
module rmsenv_divider import rmsenv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int unsigned STEP_W = $clog2(SUM_W + 1);

   logic [CNT_W:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dsor_ff, dsor_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   always_comb begin
      trial     = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
      fits      = trial >= {1'b0, dsor_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsor_in   = dsor_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dsor_in  = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial - {1'b0, dsor_ff} : trial;
         quo_in   = {quo_ff[SUM_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsor_ff  <= dsor_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/rmsenv_isqrt.sv =====
// Integer square root, one root bit (two radicand bits) per cycle.
// Depends on rmsenv_pkg for the radicand and root widths.
module rmsenv_isqrt import rmsenv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int unsigned PAD_W  = 2 * ROOT_W;
   localparam int unsigned REM_W  = ROOT_W + 3;
   localparam int unsigned STEP_W = $clog2(ROOT_W + 1);

   logic [PAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic              fits;

   always_comb begin
      shifted  = {rem_ff[REM_W-3:0], rad_ff[PAD_W-1:PAD_W-2]};
      trial    = {1'b0, root_ff, 2'b01};
      fits     = shifted >= trial;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rad_in   = {{(PAD_W-RAD_W){1'b0}}, radicand};
         rem_in   = '0;
         root_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rad_in   = {rad_ff[PAD_W-3:0], 2'b00};
         rem_in   = fits ? shifted - trial : shifted;
         root_in  = {root_ff[ROOT_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hdl/rms_envelope_follower.sv =====
// RMS envelope follower: mono mix, windowed mean square, root, gain scale and clamp.
// Depends on rmsenv_pkg, rmsenv_serial_mul, rmsenv_divider and rmsenv_isqrt.
// A frame that closes no window is held off while the bit-serial multiplier squares it.
// A frame that closes a window also runs divide, root and gain multiply, in that order;
// its word then goes to the output register, after which the next frame is taken.
// The word waits in the output register; synchronous reset restores defaults, clears state.
module rms_envelope_follower import rmsenv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample_left,
   input  logic [SAMPLE_W-1:0]   req_sample_right,
   input  logic                  req_end_of_sound,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LVL_W-1:0]      rsp_level,
   output logic                  rsp_last_window,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_SCALE  = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   localparam int unsigned WIDE_W = PROD_W + 8;
   localparam int unsigned LV_W   = WIDE_W - 31;

   logic [CH_W-1:0]   chan_ff;
   logic [CNT_W-1:0]  window_ff;
   logic [FOS_W-1:0]  cap_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [LVL_W-1:0]  ceiling_ff;

   logic [2:0]        state_ff, state_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  fiw_ff, fiw_in;
   logic [FOS_W-1:0]  fos_ff, fos_in;
   logic              capped_ff, capped_in;
   logic              eos_ff, eos_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              use_avg;
   logic signed [SAMPLE_W:0] pair_sum;
   logic signed [SAMPLE_W:0] mono;
   logic [SAMPLE_W:0] mag;
   logic [CNT_W-1:0]  win;
   logic [FOS_W-1:0]  cap;
   logic [SUM_W-1:0]  sum_new;
   logic [CNT_W-1:0]  fiw_new;
   logic [FOS_W-1:0]  fos_new;
   logic              at_cap;
   logic              emit;
   logic [WIDE_W-1:0] prod_wide;
   logic [WIDE_W-1:0] scaled;
   logic [LV_W-1:0]   level_raw;
   logic [LVL_W-1:0]  level;

   logic              mul_start, mul_done;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_product;
   logic              div_start, div_done;
   logic [SUM_W-1:0]  div_quotient;
   logic              sqrt_start, sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;

   rmsenv_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   rmsenv_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (fiw_new),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rmsenv_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quotient[RAD_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      use_avg  = (MAX_CHANNELS >= 2) && (chan_ff >= CH_W'(2));
      pair_sum = $signed({req_sample_left[SAMPLE_W-1], req_sample_left})
               + $signed({req_sample_right[SAMPLE_W-1], req_sample_right});
      if (use_avg) begin
         mono = (pair_sum + $signed({{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]})) >>> 1;
      end else begin
         mono = $signed({req_sample_left[SAMPLE_W-1], req_sample_left});
      end
      mag = mono[SAMPLE_W] ? (SAMPLE_W+1)'(-mono) : mono;

      priority if (window_ff == '0) begin
         win = CNT_W'(1);
      end else if ({2'b00, window_ff} > (CNT_W+2)'(MAX_WINDOW)) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = window_ff;
      end
      cap = (cap_ff == '0) ? FOS_W'(1) : cap_ff;

      sum_new = sum_ff + {{(SUM_W-PROD_W){1'b0}}, mul_product};
      fiw_new = fiw_ff + 1'b1;
      fos_new = fos_ff + 1'b1;
      at_cap  = fos_new >= cap;
      emit    = at_cap || eos_ff || (fiw_new >= win);

      prod_wide = {8'b0, mul_product};
      scaled    = {prod_wide[WIDE_W-9:0], 8'b0} - prod_wide;
      level_raw = scaled[WIDE_W-1:31];
      level     = (level_raw > {{(LV_W-LVL_W){1'b0}}, ceiling_ff}) ? ceiling_ff
                                                                   : level_raw[LVL_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      fiw_in       = fiw_ff;
      fos_in       = fos_ff;
      capped_in    = capped_ff;
      eos_in       = eos_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_level_in = rsp_level_ff;
      rsp_last_in  = rsp_last_ff;
      mul_start    = 1'b0;
      mul_a        = {1'b0, sqrt_root};
      mul_b        = gain_ff;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            mul_a = mag[MUL_W-1:0];
            mul_b = mag[MUL_W-1:0];
            if (accept) begin
               if (capped_ff) begin
                  if (req_end_of_sound) begin
                     capped_in = 1'b0;
                     fos_in    = '0;
                     sum_in    = '0;
                     fiw_in    = '0;
                  end
               end else begin
                  mul_start = 1'b1;
                  eos_in    = req_end_of_sound;
                  state_in  = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               if (emit) begin
                  div_start = 1'b1;
                  last_in   = at_cap || eos_ff;
                  sum_in    = '0;
                  fiw_in    = '0;
                  if (at_cap || eos_ff) begin
                     fos_in    = '0;
                     capped_in = at_cap && !eos_ff;
                  end else begin
                     fos_in = fos_new;
                  end
                  state_in = ST_DIVIDE;
               end else begin
                  sum_in   = sum_new;
                  fiw_in   = fiw_new;
                  fos_in   = fos_new;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               mul_start = 1'b1;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mul_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      eos_ff       <= eos_in;
      last_ff      <= last_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         fiw_ff       <= '0;
         fos_ff       <= '0;
         capped_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         fiw_ff       <= fiw_in;
         fos_ff       <= fos_in;
         capped_ff    <= capped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff    <= RST_CHANNEL_COUNT;
         window_ff  <= RST_WINDOW_LEN;
         cap_ff     <= RST_FRAME_CAP;
         gain_ff    <= RST_GAIN_Q16;
         ceiling_ff <= RST_CEILING;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: chan_ff    <= csr_wdata[CH_W-1:0];
            CSR_WINDOW_LEN:    window_ff  <= csr_wdata[CNT_W-1:0];
            CSR_FRAME_CAP:     cap_ff     <= csr_wdata[FOS_W-1:0];
            CSR_GAIN_Q16:      gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_CEILING:       ceiling_ff <= csr_wdata[LVL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_last_window = rsp_last_ff;

`ifndef SYNTHESIS
   a_capped_clear: assert property (@(posedge clock) disable iff (reset)
      capped_ff |-> (fiw_ff == '0) && (sum_ff == '0))
      else $error("capped sound holds a partial window");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_done, div_done, sqrt_done}))
      else $error("two arithmetic units finished together");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mul_done && !div_done && !sqrt_done)
      else $error("arithmetic unit finished while sequencer idle");
`endif

endmodule

// ===== tb/sv/rms_envelope_follower_tb.sv =====
// Self-checking testbench for rms_envelope_follower: directed frames, then random sounds.
// Expected envelope words come from a scoreboard class that tracks the window state.
// Depends on rmsenv_pkg and the rms_envelope_follower RTL.
module rms_envelope_follower_tb import rmsenv_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned SETTLE_CYCLES   = 120;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned FRAMES_PER_PHASE = 100;
   localparam int unsigned MAX_REPORTS     = 10;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             last_window;
   } envelope_word_type;

   class scoreboard_type;
      logic [CH_W-1:0]   channel_count;
      logic [CNT_W-1:0]  window_len;
      logic [FOS_W-1:0]  frame_cap;
      logic [GAIN_W-1:0] gain_q16;
      logic [LVL_W-1:0]  ceiling;
      logic [SUM_W-1:0]  square_sum;
      logic [CNT_W-1:0]  frames_in_window;
      logic [FOS_W-1:0]  frames_of_sound;
      logic              capped;
      envelope_word_type levels_due[$];
      int unsigned       mismatches;

      function new();
         channel_count    = RST_CHANNEL_COUNT;
         window_len       = RST_WINDOW_LEN;
         frame_cap        = RST_FRAME_CAP;
         gain_q16         = RST_GAIN_Q16;
         ceiling          = RST_CEILING;
         square_sum       = '0;
         frames_in_window = '0;
         frames_of_sound  = '0;
         capped           = 1'b0;
         mismatches       = 0;
      endfunction

      function void write_register(csr_index_type index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_CHANNEL_COUNT: channel_count = data[CH_W-1:0];
            CSR_WINDOW_LEN:    window_len    = data[CNT_W-1:0];
            CSR_FRAME_CAP:     frame_cap     = data[FOS_W-1:0];
            CSR_GAIN_Q16:      gain_q16      = data[GAIN_W-1:0];
            CSR_CEILING:       ceiling       = data[LVL_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_frame(sample_type left, sample_type right, logic eos);
         int unsigned       channels;
         int unsigned       window;
         int unsigned       cap;
         int                mono;
         int                bit_pos;
         longint unsigned   mag;
         longint unsigned   mean;
         longint unsigned   root;
         longint unsigned   trial;
         longint unsigned   scaled;
         logic              at_cap;
         envelope_word_type word;

         if (capped) begin
            // drop until the end of the sound
            if (eos) begin
               capped           = 1'b0;
               frames_of_sound  = '0;
               square_sum       = '0;
               frames_in_window = '0;
            end
            return;
         end

         channels = (channel_count == 0) ? 1 : channel_count;
         if (channels > MAX_CHANNELS) channels = MAX_CHANNELS;
         window = (window_len == 0) ? 1 : window_len;
         if (window > MAX_WINDOW) window = MAX_WINDOW;
         cap = (frame_cap == 0) ? 1 : frame_cap;

         mono = (channels >= 2) ? (int'(left) + int'(right)) / 2 : int'(left);
         mag = longint'((mono < 0) ? -mono : mono);
         square_sum = square_sum + mag * mag;
         frames_in_window++;
         frames_of_sound++;

         at_cap = (frames_of_sound >= cap);
         if (at_cap || eos || frames_in_window >= window) begin
            mean = square_sum / frames_in_window;
            root = 0;
            for (bit_pos = 20; bit_pos >= 0; bit_pos--) begin
               trial = root | (64'd1 << bit_pos);
               if (trial * trial <= mean) root = trial;
            end
            scaled = (root * gain_q16 * 64'd255) >> 31;
            word.level       = (scaled > ceiling) ? ceiling : scaled[LVL_W-1:0];
            word.last_window = at_cap || eos;
            levels_due.push_back(word);
            square_sum       = '0;
            frames_in_window = '0;
            if (word.last_window) begin
               frames_of_sound = '0;
               capped          = at_cap && !eos;
            end
         end
      endfunction

      function void check_word(logic [LVL_W-1:0] level, logic last_window);
         envelope_word_type due;

         if (levels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected word: level %0d last_window %0b", level, last_window);
            return;
         end
         due = levels_due.pop_front();
         if (due.level !== level || due.last_window !== last_window) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("word mismatch: expected %0d/%0b, got %0d/%0b",
                        due.level, due.last_window, level, last_window);
         end
      endfunction

      function int pending();
         return levels_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample_left;
   logic [SAMPLE_W-1:0]   req_sample_right;
   logic                  req_end_of_sound;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [LVL_W-1:0]      rsp_level;
   logic                  rsp_last_window;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   scoreboard_type     envelope = new();
   int unsigned        sender_idle_pct   = 7;
   int unsigned        receiver_idle_pct = 69;
   int unsigned        cycle_count       = 0;

   rms_envelope_follower i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .req_end_of_sound (req_end_of_sound),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level        (rsp_level),
      .rsp_last_window  (rsp_last_window),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rms_envelope_follower test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            envelope.note_frame(req_sample_left, req_sample_right, req_end_of_sound);
         if (rsp_valid && !rsp_stall)
            envelope.check_word(rsp_level, rsp_last_window);
      end
   end

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return sample_type'(16'h7FFF);
         1: return sample_type'(16'h8000);
         2: return sample_type'(int'($urandom_range(0, 15)) - 8);
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic send_frame(input sample_type left, input sample_type right, input logic eos);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_left  <= left;
      req_sample_right <= right;
      req_end_of_sound <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (envelope.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      envelope.write_register(index, data);
      @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] channels, window, cap, gain, ceil);
      write_csr(CSR_CHANNEL_COUNT, channels);
      write_csr(CSR_WINDOW_LEN, window);
      write_csr(CSR_FRAME_CAP, cap);
      write_csr(CSR_GAIN_Q16, gain);
      write_csr(CSR_CEILING, ceil);
      csr_we <= 1'b0;
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] window;
      logic [CSR_DATA_W-1:0] cap;
      logic [CSR_DATA_W-1:0] gain;

      case ($urandom_range(0, 9))
         0:       window = '0;
         1:       window = CSR_DATA_W'($urandom_range(MAX_WINDOW + 1, 2047));
         2:       window = CSR_DATA_W'(MAX_WINDOW);
         3, 4:    window = CSR_DATA_W'($urandom_range(9, 64));
         default: window = CSR_DATA_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: cap = CSR_DATA_W'($urandom_range(0, 40));
         4, 5, 6:    cap = CSR_DATA_W'($urandom_range(41, 2000));
         default:    cap = CSR_DATA_W'($urandom_range(0, 20'hFFFFF));
      endcase
      case ($urandom_range(0, 9))
         0:       gain = '0;
         1:       gain = 20'd65536;
         default: gain = CSR_DATA_W'($urandom_range(0, (1 << GAIN_W) - 1));
      endcase
      configure(CSR_DATA_W'($urandom_range(0, 3)), window, cap, gain,
                CSR_DATA_W'($urandom_range(0, 255)));
   endtask

   task automatic run_random_phase(input int unsigned frames);
      int unsigned sent;
      int unsigned length;
      int unsigned k;
      bit          noisy;

      sent = 0;
      while (sent < frames) begin
         noisy  = ($urandom_range(0, 99) < 20);
         length = $urandom_range(1, 48);
         if (length > frames - sent) length = frames - sent;
         for (k = 1; k <= length; k++)
            send_frame(pick_sample(), pick_sample(),
                       noisy ? ($urandom_range(0, 3) == 0) : (k == length));
         sent += length;
      end
   endtask

   initial begin
      int unsigned phase;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_left  = '0;
      req_sample_right = '0;
      req_end_of_sound = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_CHANNEL_COUNT;
      csr_wdata        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default registers
      send_frame(16'sh7FFF, 16'sh0000, 1'b0);
      send_frame(-16'sh8000, 16'sh7FFF, 1'b0);
      send_frame(16'sh0000, 16'sh0000, 1'b1);
      settle();

      // two channels, truncation toward zero, full gain
      configure(20'd2, 20'd2, 20'hFFFFF, 20'd65536, 20'd255);
      send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_frame(-16'sh8000, -16'sh8000, 1'b0);
      send_frame(-16'sh0001, 16'sh0000, 1'b0);
      send_frame(16'sh0001, -16'sh0002, 1'b0);
      send_frame(-16'sh8000, 16'sh7FFF, 1'b1);
      settle();

      // zero channels, window and cap; cap then drop, then cap and end together
      configure(20'd0, 20'd0, 20'd0, 20'h1FFFF, 20'd255);
      send_frame(16'sh7FFF, 16'sh1234, 1'b0);
      send_frame(16'sh4000, 16'sh0000, 1'b0);
      send_frame(16'sh0100, 16'sh0000, 1'b1);
      send_frame(-16'sh8000, 16'sh0005, 1'b1);
      settle();

      // three channels, oversized window, zero gain and ceiling
      configure(20'd3, 20'd2047, 20'd3, 20'd0, 20'd0);
      send_frame(-16'sh8000, 16'sh7FFF, 1'b0);
      send_frame(16'sh0064, 16'sh00C8, 1'b0);
      send_frame(16'sh0005, 16'sh0005, 1'b0);
      send_frame(16'sh0001, 16'sh0001, 1'b1);
      settle();

      // shrink the window while frames are held
      configure(20'd1, 20'd1000, 20'hFFFFF, 20'd65536, 20'd255);
      send_frame(16'sh2000, 16'sh0000, 1'b0);
      send_frame(-16'sh3000, 16'sh0000, 1'b0);
      send_frame(16'sh7FFF, 16'sh0000, 1'b0);
      settle();
      configure(20'd1, 20'd2, 20'hFFFFF, 20'd65536, 20'd255);
      send_frame(16'sh04D2, 16'sh0000, 1'b0);
      send_frame(-16'sh0005, 16'sh0000, 1'b1);
      settle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         sender_idle_pct   = (phase < 3) ? 7 : (phase < 6) ? 69 : 0;
         receiver_idle_pct = (phase < 3) ? 69 : (phase < 6) ? 7 : 0;
         random_config();
         run_random_phase(FRAMES_PER_PHASE);
         settle();
      end

      if (envelope.mismatches == 0 && envelope.pending() == 0)
         $display("rms_envelope_follower test passed");
      else
         $display("rms_envelope_follower test failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rmsenv_pkg.sv
hdl/rmsenv_serial_mul.sv
hdl/rmsenv_divider.sv
hdl/rmsenv_isqrt.sv
hdl/rms_envelope_follower.sv
tb/sv/rms_envelope_follower_tb.sv
